// ===== hw/rtl/fla_pkg.sv =====
`timescale 1ns / 1ps
package fla_pkg;

  localparam int TID_W       = 3;
  localparam int LVL_OUT_W   = 3;
  localparam int CNT_W       = 4;
  localparam int TDATA_IN_W  = 8;
  localparam int TUSER_IN_W  = 1;
  localparam int TDATA_OUT_W = 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic REQ_POLL    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // register index sits in paddr[2]
  localparam logic REG_IDX_NUM_THREADS = 1'b0;

  localparam logic [CNT_W-1:0] NUM_THREADS_RST = 4'd8;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic [TID_W-1:0] k;
    logic [TID_W-1:0] t;
  } scan_ctl_t;

endpackage

// ===== hw/rtl/fla_mem.sv =====
`timescale 1ns / 1ps
module fla_mem #(
  parameter int DEPTH = 8,
  parameter int DW    = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

// ===== hw/rtl/fla_scan.sv =====
`timescale 1ns / 1ps
module fla_scan #(
  parameter int LW = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  fla_pkg::scan_ctl_t ctl,
  input  logic [LW-1:0]     lvl,
  input  logic [LW-1:0]     rdata,
  output logic              hit_any
);
  import fla_pkg::*;

  logic hit;
  logic cur;

  assign cur     = ctl.en && (ctl.k != ctl.t) && (rdata >= lvl);
  assign hit_any = hit | cur;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      hit <= 1'b0;
    end else begin
      hit <= hit_any;
    end
  end

endmodule

// ===== hw/rtl/filter_lock_arbiter.sv =====
`timescale 1ns / 1ps
// Flow, accept to result beat: a rejected id goes straight to write-back; a release, a held
// lock, a count of one or a poll at level 0 finishes after the level lookup; a poll that is
// not its level's victim finishes after the victim check; a victim poll scans every active
// thread's level on the single read port, one compare per cycle, then drains and writes back.
// Throughput: one item at a time; input ready returns the cycle after the result is loaded.
// Reset clears all levels, victims and grants and sets the thread count to 8.
module filter_lock_arbiter #(
  parameter int MAX_THREADS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] requester id, [7:3] zero
  input  logic [fla_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  // [0] req_type
  input  logic [fla_pkg::TUSER_IN_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] granted, [1] blocked, [4:2] level_now, [5] rejected, [7:6] zero
  output logic [fla_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fla_pkg::PADDR_W-1:0]      paddr,
  input  logic [fla_pkg::PDATA_W-1:0]      pwdata,
  output logic [fla_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import fla_pkg::*;

  localparam int NTHR = (MAX_THREADS < (1 << TID_W)) ? MAX_THREADS : (1 << TID_W);
  localparam int TIW  = $clog2(NTHR);
  localparam int LW   = $clog2(MAX_THREADS);
  localparam int CW   = (LW > CNT_W) ? LW : CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_VCHK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] num_threads;
  logic [NTHR-1:0]  holds;
  logic             pv;

  logic [TID_W-1:0] t_r;
  logic             req_r;
  logic [CNT_W-1:0] n_r;
  logic [LW-1:0]    lvl_r;
  logic [TIW-1:0]   k;
  logic [TIW-1:0]   pk;

  logic                 res_gr;
  logic                 res_bl;
  logic                 res_rej;
  logic [LVL_OUT_W-1:0] res_lvl;

  logic          lw_en;
  logic [LW-1:0] lw_val;
  logic          vw_en;
  logic [LW-1:0] vw_addr;
  logic          h_set;
  logic          h_clr;

  logic             in_acc;
  logic             fin_go;
  logic             cfg_wr;
  logic [CNT_W-1:0] n_eff;
  logic             rej;
  logic [TID_W-1:0] tid;
  logic             hold_t;
  logic             look_done;
  logic [TIW-1:0]   scan_last;
  logic             adv_top;
  logic [LW-1:0]    adv_next;
  logic             hit_any;

  logic [TIW-1:0] lvl_raddr;
  logic [LW-1:0]  lvl_rdata;
  logic [LW-1:0]  vic_rdata;
  logic [TID_W-1:0] vic_rdata_t;
  logic           lvl_we;
  logic           vic_we;

  scan_ctl_t scan_ctl;

  assign tid           = s_axis_tdata[TID_W-1:0];
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fin_go        = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_IDX_NUM_THREADS) ? PDATA_W'(num_threads) : '0;

  always_comb begin
    if (num_threads == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_threads) > MAX_THREADS) begin
      n_eff = CNT_W'(MAX_THREADS);
    end else begin
      n_eff = num_threads;
    end
  end

  assign rej = ({1'b0, tid} >= n_eff);

  always_comb begin
    if (int'(n_r) > NTHR) begin
      scan_last = TIW'(NTHR - 1);
    end else begin
      scan_last = TIW'(n_r - CNT_W'(1));
    end
  end

  assign hold_t    = holds[TIW'(t_r)];
  assign look_done = (req_r == REQ_RELEASE) || hold_t || (n_r == CNT_W'(1)) ||
                     (lvl_rdata == '0);
  assign adv_top   = (CW'(lvl_r) >= (CW'(n_r) - CW'(1)));
  assign adv_next  = lvl_r + LW'(1);

  assign lvl_raddr = (state == S_IDLE) ? TIW'(tid) : k;
  assign lvl_we    = fin_go && lw_en;
  assign vic_we    = fin_go && vw_en;
  assign vic_rdata_t = TID_W'(vic_rdata);

  fla_mem #(
    .DEPTH (NTHR),
    .DW    (LW)
  ) u_level_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (lvl_we),
    .waddr (TIW'(t_r)),
    .wdata (lw_val),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  fla_mem #(
    .DEPTH (MAX_THREADS),
    .DW    (LW)
  ) u_victim_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (vic_we),
    .waddr (vw_addr),
    .wdata (LW'(t_r)),
    .raddr (lvl_rdata),
    .rdata (vic_rdata)
  );

  assign scan_ctl.clr = (state == S_VCHK);
  assign scan_ctl.en  = pv;
  assign scan_ctl.k   = TID_W'(pk);
  assign scan_ctl.t   = t_r;

  fla_scan #(
    .LW (LW)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .lvl     (lvl_r),
    .rdata   (lvl_rdata),
    .hit_any (hit_any)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = rej ? S_FIN : S_LOOK;
        end
      end
      S_LOOK:  state_next = look_done ? S_FIN : S_VCHK;
      S_VCHK:  state_next = (vic_rdata_t != t_r) ? S_FIN : S_SCAN;
      S_SCAN:  state_next = (k == scan_last) ? S_DRAIN : S_SCAN;
      S_DRAIN: state_next = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      num_threads   <= NUM_THREADS_RST;
      holds         <= '0;
      pv            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= (state == S_SCAN);
      if (cfg_wr && (paddr[2] == REG_IDX_NUM_THREADS)) begin
        num_threads <= pwdata[CNT_W-1:0];
      end
      if (fin_go && h_set) begin
        holds[TIW'(t_r)] <= 1'b1;
      end
      if (fin_go && h_clr) begin
        holds[TIW'(t_r)] <= 1'b0;
      end
      if (fin_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          t_r     <= tid;
          req_r   <= s_axis_tuser[0];
          n_r     <= n_eff;
          res_rej <= rej;
          res_gr  <= 1'b0;
          res_bl  <= 1'b0;
          res_lvl <= '0;
          lw_en   <= 1'b0;
          vw_en   <= 1'b0;
          h_set   <= 1'b0;
          h_clr   <= 1'b0;
        end
      end
      S_LOOK: begin
        lvl_r <= lvl_rdata;
        if (req_r == REQ_RELEASE) begin
          lw_en  <= 1'b1;
          lw_val <= '0;
          h_clr  <= 1'b1;
        end else if (hold_t) begin
          res_gr  <= 1'b1;
          res_lvl <= LVL_OUT_W'(lvl_rdata);
        end else if (n_r == CNT_W'(1)) begin
          h_set   <= 1'b1;
          res_gr  <= 1'b1;
          res_lvl <= LVL_OUT_W'(lvl_rdata);
        end else if (lvl_rdata == '0) begin
          lw_en   <= 1'b1;
          lw_val  <= LW'(1);
          vw_en   <= 1'b1;
          vw_addr <= LW'(1);
          res_lvl <= LVL_OUT_W'(1);
        end
      end
      S_VCHK: begin
        k <= '0;
        if (vic_rdata_t != t_r) begin
          res_gr  <= adv_top;
          res_lvl <= LVL_OUT_W'(adv_top ? lvl_r : adv_next);
          h_set   <= adv_top;
          lw_en   <= !adv_top;
          lw_val  <= adv_next;
          vw_en   <= !adv_top;
          vw_addr <= adv_next;
        end
      end
      S_SCAN: begin
        pk <= k;
        k  <= k + TIW'(1);
      end
      S_DRAIN: begin
        if (hit_any) begin
          res_bl  <= 1'b1;
          res_lvl <= LVL_OUT_W'(lvl_r);
        end else begin
          res_gr  <= adv_top;
          res_lvl <= LVL_OUT_W'(adv_top ? lvl_r : adv_next);
          h_set   <= adv_top;
          lw_en   <= !adv_top;
          lw_val  <= adv_next;
          vw_en   <= !adv_top;
          vw_addr <= adv_next;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          m_axis_tdata <= {2'b00, res_rej, res_lvl, res_bl, res_gr};
        end
      end
      default: begin
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  a_grant_not_blocked: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("result both granted and blocked");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[4:0] == 5'd0))
    else $error("rejected beat carries grant, block or level");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_FIN))
    else $error("result beat raised outside write-back");

  a_write_in_fin: assert property (@(posedge clk) disable iff (rst)
    (lvl_we || vic_we) |-> (state == S_FIN))
    else $error("memory write outside write-back");

endmodule

// ===== tb/tb_filter_lock_arbiter.sv =====
`timescale 1ns / 1ps
module tb_filter_lock_arbiter;
  import fla_pkg::*;

  localparam int THREADS   = 8;
  localparam int CLK_LIMIT = 400000;
  localparam int SETTLE    = 16;

  typedef struct packed {
    logic                 rejected;
    logic [LVL_OUT_W-1:0] level_now;
    logic                 blocked;
    logic                 granted;
  } verdict_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic [TUSER_IN_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  logic [TID_W-1:0] lvl_of[THREADS];
  logic [TID_W-1:0] victim_of[THREADS];
  logic             owner[THREADS];
  logic [CNT_W-1:0] lock_count;
  verdict_t         pending_verdicts[$];
  int               errors;
  bit               idle_on;
  int               stall_left;
  int               cycles;

  filter_lock_arbiter #(
    .MAX_THREADS(THREADS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int active_threads(input logic [CNT_W-1:0] value);
    if (value == 0) return 1;
    if (value > THREADS) return THREADS;
    return int'(value);
  endfunction

  function automatic verdict_t arbitrate(input logic req, input logic [TID_W-1:0] tid);
    int       n;
    int       lvl;
    bit       stuck;
    verdict_t v;
    n = active_threads(lock_count);
    v = '0;
    if (int'(tid) >= n) begin
      v.rejected = 1'b1;
      return v;
    end
    if (req == REQ_RELEASE) begin
      lvl_of[tid] = '0;
      owner[tid]  = 1'b0;
    end else if (owner[tid]) begin
      v.granted = 1'b1;
    end else if (n == 1) begin
      owner[tid] = 1'b1;
      v.granted  = 1'b1;
    end else begin
      lvl = int'(lvl_of[tid]);
      if (lvl == 0) begin
        lvl_of[tid]  = TID_W'(1);
        victim_of[1] = tid;
      end else begin
        stuck = 1'b0;
        if (victim_of[lvl] == tid) begin
          for (int k = 0; k < n; k++) begin
            if (k != int'(tid) && int'(lvl_of[k]) >= lvl) stuck = 1'b1;
          end
        end
        if (stuck) begin
          v.blocked = 1'b1;
        end else if (lvl >= n - 1) begin
          owner[tid] = 1'b1;
          v.granted  = 1'b1;
        end else begin
          lvl_of[tid]        = TID_W'(lvl + 1);
          victim_of[lvl + 1] = tid;
        end
      end
    end
    v.level_now = lvl_of[tid];
    return v;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_beats
    verdict_t want;
    verdict_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[5:0]);
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: beat mismatch, expected g%0b b%0b lvl%0d r%0b, actual g%0b b%0b lvl%0d r%0b",
                   $time, want.granted, want.blocked, want.level_now, want.rejected,
                   got.granted, got.blocked, got.level_now, got.rejected);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CLK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_request(input logic req, input logic [TID_W-1:0] tid);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= TDATA_IN_W'(tid);
    do @(posedge clk); while (!s_axis_tready);
    pending_verdicts.push_back(arbitrate(req, tid));
  endtask

  task automatic drain_arbiter();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_thread_count(input logic [CNT_W-1:0] value);
    logic [PDATA_W-1:0] word;
    word        = $urandom();
    word[CNT_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDX_NUM_THREADS, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lock_count = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_thread_count();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_IDX_NUM_THREADS, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(lock_count)) begin
      errors++;
      $display("%0t: thread count readback, expected %h, actual %h",
               $time, PDATA_W'(lock_count), prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_contention();
    read_thread_count();
    push_request(REQ_POLL, 3'd7);
    push_request(REQ_POLL, 3'd0);
    push_request(REQ_POLL, 3'd0);
    push_request(REQ_POLL, 3'd7);
    push_request(REQ_RELEASE, 3'd7);
    push_request(REQ_RELEASE, 3'd0);
  endtask

  task automatic test_single_thread();
    drain_arbiter();
    write_thread_count(4'd1);
    read_thread_count();
    push_request(REQ_POLL, 3'd0);
    push_request(REQ_POLL, 3'd0);
    push_request(REQ_POLL, 3'd1);
    push_request(REQ_RELEASE, 3'd0);
  endtask

  task automatic test_count_extremes();
    drain_arbiter();
    write_thread_count(4'd0);
    read_thread_count();
    push_request(REQ_POLL, 3'd0);
    push_request(REQ_POLL, 3'd1);
    push_request(REQ_RELEASE, 3'd0);
    drain_arbiter();
    write_thread_count(4'd15);
    read_thread_count();
    push_request(REQ_POLL, 3'd7);
    push_request(REQ_RELEASE, 3'd7);
  endtask

  task automatic test_lowered_count();
    drain_arbiter();
    write_thread_count(4'd4);
    repeat (3) push_request(REQ_POLL, 3'd1);
    drain_arbiter();
    write_thread_count(4'd2);
    push_request(REQ_POLL, 3'd1);
    push_request(REQ_RELEASE, 3'd1);
  endtask

  task automatic test_random_phases();
    int   counts[12] = '{8, 2, 3, 0, 5, 12, 1, 7, 4, 15, 6, 8};
    int   n;
    int   tid;
    logic req;
    for (int p = 0; p < 12; p++) begin
      drain_arbiter();
      write_thread_count(CNT_W'(counts[p]));
      read_thread_count();
      n = active_threads(CNT_W'(counts[p]));
      if (p == 11) idle_on = 1'b0;
      repeat (120) begin
        if ($urandom_range(0, 4) == 0) begin
          req = 1'($urandom_range(0, 1));
          tid = $urandom_range(0, THREADS - 1);
        end else begin
          tid = $urandom_range(0, n - 1);
          req = (owner[tid] && $urandom_range(0, 1) == 1) ? REQ_RELEASE : REQ_POLL;
        end
        push_request(req, TID_W'(tid));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    lock_count    = NUM_THREADS_RST;
    errors        = 0;
    idle_on       = 1'b1;
    stall_left    = 0;
    cycles        = 0;
    for (int i = 0; i < THREADS; i++) begin
      lvl_of[i]    = '0;
      victim_of[i] = '0;
      owner[i]     = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_contention();
    test_single_thread();
    test_count_extremes();
    test_lowered_count();
    test_random_phases();
    drain_arbiter();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
